### rtl/hee_pkg.sv
package hee_pkg;

	// Longest escaped run and its index width
	localparam int RUN_MAX = 6;
	localparam int RUN_IW  = $clog2(RUN_MAX);
	localparam int LEN_W   = $clog2(RUN_MAX + 1);

	// Queue between classifier and serializer
	localparam int QDEPTH  = 2;
	localparam int QPTR_W  = $clog2(QDEPTH);
	localparam int QCNT_W  = $clog2(QDEPTH + 1);

	// Character codes
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_QUOT  = 8'h22;
	localparam logic [7:0] CH_HASH  = 8'h23;
	localparam logic [7:0] CH_AMP   = 8'h26;
	localparam logic [7:0] CH_APOS  = 8'h27;
	localparam logic [7:0] CH_SEMI  = 8'h3B;
	localparam logic [7:0] CH_LT    = 8'h3C;
	localparam logic [7:0] CH_GT    = 8'h3E;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CTRL_MAX = 8'h1F;
	localparam logic [7:0] CH_DEL   = 8'h7F;

	typedef logic [7:0] char_t;

	// One classified item: the escaped run, its length and the string-end flag
	typedef struct packed {
		char_t [RUN_MAX-1:0] chars;
		logic [LEN_W-1:0]    len;
		logic                str_end;
	} run_t;

endpackage

### rtl/hee_front.sv
module hee_front (
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // in_byte
	input  logic        s_tlast,   // in_string_end
	input  logic        q_full,
	output logic        q_push,
	output hee_pkg::run_t q_data
);
	import hee_pkg::*;

	logic [1:0]  hund;
	logic [7:0]  rem8;
	logic [6:0]  rem7;
	logic [14:0] prod;
	logic [3:0]  tens;
	logic [6:0]  ones7;
	logic [3:0]  ones;
	logic        numeric;
	run_t        r;

	assign s_tready = !q_full;
	assign q_push   = s_tvalid && !q_full;
	assign q_data   = r;

	// Split the byte into decimal digits
	always_comb begin
		if (s_tdata >= 8'd200) begin
			hund = 2'd2;
			rem8 = s_tdata - 8'd200;
		end else if (s_tdata >= 8'd100) begin
			hund = 2'd1;
			rem8 = s_tdata - 8'd100;
		end else begin
			hund = 2'd0;
			rem8 = s_tdata;
		end
		rem7  = rem8[6:0];
		prod  = {8'b0, rem7} * 15'd205;
		tens  = prod[14:11];
		ones7 = rem7 - ({3'b0, tens} << 3) - ({3'b0, tens} << 1);
		ones  = ones7[3:0];
	end

	assign numeric = (s_tdata <= CTRL_MAX || s_tdata >= CH_DEL) &&
		s_tdata != CH_TAB && s_tdata != CH_LF && s_tdata != CH_CR;

	// Classify the byte and build its run
	always_comb begin
		r = '0;
		r.str_end = s_tlast;
		unique case (s_tdata)
			CH_LT: begin
				r.chars[0] = CH_AMP; r.chars[1] = "l"; r.chars[2] = "t";
				r.chars[3] = CH_SEMI;
				r.len = LEN_W'(4);
			end
			CH_GT: begin
				r.chars[0] = CH_AMP; r.chars[1] = "g"; r.chars[2] = "t";
				r.chars[3] = CH_SEMI;
				r.len = LEN_W'(4);
			end
			CH_QUOT: begin
				r.chars[0] = CH_AMP; r.chars[1] = "q"; r.chars[2] = "u";
				r.chars[3] = "o"; r.chars[4] = "t"; r.chars[5] = CH_SEMI;
				r.len = LEN_W'(6);
			end
			CH_AMP: begin
				r.chars[0] = CH_AMP; r.chars[1] = "a"; r.chars[2] = "m";
				r.chars[3] = "p"; r.chars[4] = CH_SEMI;
				r.len = LEN_W'(5);
			end
			CH_APOS: begin
				r.chars[0] = CH_AMP; r.chars[1] = "a"; r.chars[2] = "p";
				r.chars[3] = "o"; r.chars[4] = "s"; r.chars[5] = CH_SEMI;
				r.len = LEN_W'(6);
			end
			default: begin
				if (numeric) begin
					r.chars[0] = CH_AMP;
					r.chars[1] = CH_HASH;
					if (hund != 2'd0) begin
						r.chars[2] = CH_ZERO | {6'b0, hund};
						r.chars[3] = CH_ZERO | {4'b0, tens};
						r.chars[4] = CH_ZERO | {4'b0, ones};
						r.chars[5] = CH_SEMI;
						r.len = LEN_W'(6);
					end else if (tens != 4'd0) begin
						r.chars[2] = CH_ZERO | {4'b0, tens};
						r.chars[3] = CH_ZERO | {4'b0, ones};
						r.chars[4] = CH_SEMI;
						r.len = LEN_W'(5);
					end else begin
						r.chars[2] = CH_ZERO | {4'b0, ones};
						r.chars[3] = CH_SEMI;
						r.len = LEN_W'(4);
					end
				end else begin
					r.chars[0] = s_tdata;
					r.len = LEN_W'(1);
				end
			end
		endcase
	end

endmodule

### rtl/hee_queue.sv
module hee_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  hee_pkg::run_t push_data,
	output logic          full,
	input  logic          pop,
	output logic          empty,
	output hee_pkg::run_t head
);
	import hee_pkg::*;

	run_t              mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_q;
	logic [QPTR_W-1:0] rd_q;
	logic [QCNT_W-1:0] cnt_q;

	assign full  = cnt_q == QCNT_W'(QDEPTH);
	assign empty = cnt_q == '0;
	assign head  = mem_q[rd_q];

	// Store incoming runs
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_data;
		end
	end

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

### rtl/hee_back.sv
module hee_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          q_empty,
	input  hee_pkg::run_t q_head,
	output logic          q_pop,
	output logic          m_tvalid,
	input  logic          m_tready,
	output logic [7:0]    m_tdata,   // out_byte
	output logic          m_tlast,   // run_last
	output logic          m_tuser    // out_string_end
);
	import hee_pkg::*;

	run_t              cur_q;
	logic              busy_q;
	logic [RUN_IW-1:0] idx_q;
	logic              vld_q;
	char_t             data_q;
	logic              last_q;
	logic              send_end_q;
	logic              out_free;
	logic              cur_last;
	logic              emit;

	assign out_free = !vld_q || m_tready;
	assign cur_last = LEN_W'(idx_q) == cur_q.len - 1'b1;
	assign emit     = busy_q && out_free;
	assign q_pop    = !q_empty && (!busy_q || (emit && cur_last));

	assign m_tvalid = vld_q;
	assign m_tdata  = data_q;
	assign m_tlast  = last_q;
	assign m_tuser  = send_end_q;

	// Load the next run from the queue
	always_ff @(posedge clk) begin
		if (q_pop) begin
			cur_q <= q_head;
		end
	end

	// Step through the current run
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= '0;
		end else begin
			if (q_pop) begin
				busy_q <= 1'b1;
				idx_q  <= '0;
			end else if (emit) begin
				if (cur_last) begin
					busy_q <= 1'b0;
				end else begin
					idx_q <= idx_q + 1'b1;
				end
			end
		end
	end

	// Hold the output word until it is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (out_free) begin
			vld_q <= busy_q;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			data_q     <= cur_q.chars[idx_q];
			last_q     <= cur_last;
			send_end_q <= cur_last && cur_q.str_end;
		end
	end

endmodule

### rtl/html_escape_encoder.sv
// Channel   Dir  tdata          tlast          tuser
// s_axis    in   in_byte[7:0]   in_string_end  -
// m_axis    out  out_byte[7:0]  run_last       out_string_end
//
// A byte is classified in the cycle it is accepted and queued (two entries).
// The serializer sends one output word per cycle unless the output stalls,
// 1 to 6 words per input byte, so input is taken no faster than runs drain.
// The first word goes through the queue, run register and output register.
// arst_n clears the queue, serializer and output valid; output stalls back up
// through the queue to s_axis_tready.
module html_escape_encoder (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_axis_tvalid,
	output logic       s_axis_tready,
	input  logic [7:0] s_axis_tdata,   // in_byte
	input  logic       s_axis_tlast,   // in_string_end
	output logic       m_axis_tvalid,
	input  logic       m_axis_tready,
	output logic [7:0] m_axis_tdata,   // out_byte
	output logic       m_axis_tlast,   // run_last
	output logic       m_axis_tuser    // out_string_end
);
	import hee_pkg::*;

	logic q_full;
	logic q_push;
	logic q_pop;
	logic q_empty;
	run_t q_in;
	run_t q_head;

	hee_front u_front (
		.s_tvalid (s_axis_tvalid),
		.s_tready (s_axis_tready),
		.s_tdata  (s_axis_tdata),
		.s_tlast  (s_axis_tlast),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_data   (q_in)
	);

	hee_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_in),
		.full      (q_full),
		.pop       (q_pop),
		.empty     (q_empty),
		.head      (q_head)
	);

	hee_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_empty  (q_empty),
		.q_head   (q_head),
		.q_pop    (q_pop),
		.m_tvalid (m_axis_tvalid),
		.m_tready (m_axis_tready),
		.m_tdata  (m_axis_tdata),
		.m_tlast  (m_axis_tlast),
		.m_tuser  (m_axis_tuser)
	);

endmodule

### verif/escape_stream_checker.sv
module escape_stream_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	input  logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // in_byte
	input  logic        s_axis_tlast,   // in_string_end
	input  logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	input  logic [7:0]  m_axis_tdata,   // out_byte
	input  logic        m_axis_tlast,   // run_last
	input  logic        m_axis_tuser,   // out_string_end
	output int unsigned mismatches,
	output int unsigned words_pending
);
	import hee_pkg::*;

	localparam int REPORT_MAX = 10;

	typedef struct packed {
		char_t ch;
		logic  run_last;
		logic  str_end;
	} esc_word_t;

	// Escaped words still owed by the block, oldest first
	esc_word_t escaped_words[$];
	esc_word_t want;

	// Queue the escaped run for one accepted text byte
	function automatic void predict_escape(input char_t b, input logic str_end);
		char_t                run [RUN_MAX];
		logic [8*RUN_MAX-1:0] entity;
		int                   len;
		int                   k;
		entity = '0;
		len    = 0;
		case (b)
			CH_LT:   begin entity = "&lt;";   len = 4; end
			CH_GT:   begin entity = "&gt;";   len = 4; end
			CH_QUOT: begin entity = "&quot;"; len = 6; end
			CH_AMP:  begin entity = "&amp;";  len = 5; end
			CH_APOS: begin entity = "&apos;"; len = 6; end
			default: len = 0;
		endcase
		if (len != 0) begin
			// named entity: first character sits in the top byte of the literal
			for (k = 0; k < len; k++)
				run[k] = entity[8*(len-1-k) +: 8];
		end else if ((b <= CTRL_MAX || b >= CH_DEL) && b != CH_TAB && b != CH_LF
				&& b != CH_CR) begin
			// decimal entity, no leading zeros
			run[0] = CH_AMP;
			run[1] = CH_HASH;
			len = 2;
			if (b >= 100) begin
				run[len] = char_t'(CH_ZERO + b / 100);
				len = len + 1;
			end
			if (b >= 10) begin
				run[len] = char_t'(CH_ZERO + (b / 10) % 10);
				len = len + 1;
			end
			run[len] = char_t'(CH_ZERO + b % 10);
			run[len+1] = CH_SEMI;
			len = len + 2;
		end else begin
			run[0] = b;
			len = 1;
		end
		for (k = 0; k < len; k++)
			escaped_words.push_back('{run[k], k == len - 1, (k == len - 1) && str_end});
	endfunction

	// Predict on each accepted input word, compare each accepted output word
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready)
				predict_escape(s_axis_tdata, s_axis_tlast);
			if (m_axis_tvalid && m_axis_tready) begin
				if (escaped_words.size() == 0) begin
					if (mismatches < REPORT_MAX)
						$display("unexpected word: byte %02h run_last %0b end %0b",
							m_axis_tdata, m_axis_tlast, m_axis_tuser);
					mismatches = mismatches + 1;
				end else begin
					want = escaped_words.pop_front();
					if (want.ch !== m_axis_tdata || want.run_last !== m_axis_tlast
							|| want.str_end !== m_axis_tuser) begin
						if (mismatches < REPORT_MAX)
							$display("mismatch: expected %02h/%0b/%0b got %02h/%0b/%0b",
								want.ch, want.run_last, want.str_end,
								m_axis_tdata, m_axis_tlast, m_axis_tuser);
						mismatches = mismatches + 1;
					end
				end
			end
			words_pending <= escaped_words.size();
		end
	end

endmodule

### verif/html_escape_encoder_tb.sv
module html_escape_encoder_tb;
	import hee_pkg::*;

	localparam int QUIET_LIMIT = 2000;
	localparam int HOLD_CYCLES = 240;
	localparam int N_CORNER    = 20;

	logic       clk           = 1'b0;
	logic       arst_n        = 1'b0;
	logic       s_axis_tvalid = 1'b0;
	logic       s_axis_tready;
	logic [7:0] s_axis_tdata  = 8'h00;   // in_byte
	logic       s_axis_tlast  = 1'b0;    // in_string_end
	logic       m_axis_tvalid;
	logic       m_axis_tready = 1'b0;
	logic [7:0] m_axis_tdata;            // out_byte
	logic       m_axis_tlast;            // run_last
	logic       m_axis_tuser;            // out_string_end

	int unsigned mismatches;
	int unsigned words_pending;
	int unsigned idle_pct;
	int unsigned stall_pct;
	int unsigned hold_reqs;
	int unsigned holds_taken;
	int unsigned hold_left;
	int unsigned quiet_cycles;

	// Corner bytes: one- to three-digit entities, pass-through controls, markup
	char_t corner_bytes [N_CORNER] = '{8'h00, 8'h01, CH_TAB, CH_LF, CH_CR, 8'h0F,
		CTRL_MAX, 8'h20, CH_QUOT, CH_AMP, CH_APOS, CH_LT, CH_GT, 8'h41, 8'h63,
		8'h7E, CH_DEL, 8'h80, 8'hC8, 8'hFF};

	html_escape_encoder i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.m_axis_tuser  (m_axis_tuser)
	);

	escape_stream_checker i_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.m_axis_tuser  (m_axis_tuser),
		.mismatches    (mismatches),
		.words_pending (words_pending)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Drive output ready: random stalls, plus a long hold-off when requested
	always @(posedge clk) begin
		if (holds_taken != hold_reqs) begin
			holds_taken = hold_reqs;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left != 0) begin
			hold_left = hold_left - 1;
			m_axis_tready <= 1'b0;
		end else
			m_axis_tready <= ($urandom_range(99) >= stall_pct);
	end

	// Abort when no word moves on either side for too long
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			quiet_cycles <= 0;
		else if (quiet_cycles == QUIET_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end else
			quiet_cycles <= quiet_cycles + 1;
	end

	// Random text byte, weighted toward the classes that escape
	function automatic char_t pick_char();
		case ($urandom_range(9))
			0, 1: begin
				case ($urandom_range(4))
					0:       return CH_LT;
					1:       return CH_GT;
					2:       return CH_QUOT;
					3:       return CH_AMP;
					default: return CH_APOS;
				endcase
			end
			2:       return char_t'($urandom_range(CTRL_MAX));
			3: begin
				case ($urandom_range(2))
					0:       return CH_TAB;
					1:       return CH_LF;
					default: return CH_CR;
				endcase
			end
			4, 5:    return char_t'($urandom_range(255, CH_DEL));
			6, 7, 8: return char_t'($urandom_range(8'h7E, 8'h20));
			default: return char_t'($urandom_range(255));
		endcase
	endfunction

	// Offer one word after a random gap and hold it until accepted
	task automatic send_byte(input char_t b, input logic str_end);
		while ($urandom_range(99) < idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= b;
		s_axis_tlast  <= str_end;
		do
			@(posedge clk);
		while (!s_axis_tready);
	endtask

	// Send strings of random text; end flag on the last byte, flipped now and then
	task automatic send_strings(input int unsigned n_bytes);
		int unsigned sent;
		int unsigned len;
		int unsigned k;
		sent = 0;
		while (sent < n_bytes) begin
			len = $urandom_range(12, 1);
			for (k = 0; k < len; k++)
				send_byte(pick_char(), (k == len - 1) ^ ($urandom_range(9) == 0));
			sent = sent + len;
		end
	endtask

	// Stop offering and wait for every owed word to leave
	task automatic wait_drained();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		wait (words_pending == 0);
		@(posedge clk);
	endtask

	initial begin : stimulus
		int ph;
		int i;
		idle_pct  = 0;
		stall_pct = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// corner bytes, string end on every fourth
		for (i = 0; i < N_CORNER; i++)
			send_byte(corner_bytes[i], (i % 4) == 3);
		wait_drained();

		// random strings under each idling mix
		for (ph = 0; ph < 4; ph++) begin
			case (ph)
				0:       begin idle_pct = 0;  stall_pct = 0;  end
				1:       begin idle_pct = 70; stall_pct = 0;  end
				2:       begin idle_pct = 0;  stall_pct = 70; end
				default: begin idle_pct = 6;  stall_pct = 6;  end
			endcase
			send_strings(72);
			if (ph == 0) begin
				// hold the output off while input keeps coming, to back up the queue
				hold_reqs = hold_reqs + 1;
				send_strings(16);
			end
			wait_drained();
		end

		repeat (8) @(posedge clk);
		if (mismatches == 0 && words_pending == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

### sim.f
rtl/hee_pkg.sv
rtl/hee_front.sv
rtl/hee_queue.sv
rtl/hee_back.sv
rtl/html_escape_encoder.sv
verif/escape_stream_checker.sv
verif/html_escape_encoder_tb.sv
